// ===== sv/rdc_pkg.sv =====
// Shared types and constants for the radial distortion corrector.
// No dependencies; every other file imports this package.
package rdc_pkg;

  localparam int COORD_W    = 20;
  localparam int DELTA_W    = 23;  // centred full-frame offset
  localparam int MAG_W      = 22;  // |offset|
  localparam int R2_W       = 46;
  localparam int R2_HALF    = 23;
  localparam int COEFF_W    = 24;
  localparam int AXIS_W     = 18;
  localparam int MODE_W     = 2;
  localparam int M_W        = 32;  // inverse scale, Q.32
  localparam int S_W        = 48;  // either scale, Q.32
  localparam int S_HALF     = 24;
  localparam int ROOT_CELLS = 32;
  localparam int PROD_W     = COEFF_W + R2_W;
  localparam int V_W        = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LINE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SAMP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF       = 2'd3;

  localparam logic [MODE_W-1:0] MODE_NARROW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUM2   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SUM4   = 2'd3;

  localparam logic [MODE_W-1:0]  RST_MODE  = MODE_FULL;
  localparam logic [AXIS_W-1:0]  RST_AXIS  = 18'd131072;
  localparam logic [COEFF_W-1:0] RST_COEFF = 24'd2513572;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  // what travels alongside the arithmetic
  typedef struct packed {
    logic   op;
    logic   pass;
    coord_t line;
    coord_t samp;
    delta_t dx;
    delta_t dy;
  } side_t;

endpackage

// ===== sv/rdc_if.sv =====
// Valid/ready channels of the distortion corrector.
// Depends on rdc_pkg.
interface rdc_in_if;
  import rdc_pkg::*;
  logic   valid;
  logic   ready;
  logic   operation;
  coord_t in_line;
  coord_t in_samp;
  modport source (output valid, operation, in_line, in_samp, input ready);
  modport sink   (input valid, operation, in_line, in_samp, output ready);
endinterface

interface rdc_out_if;
  import rdc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_line;
  coord_t out_samp;
  logic   saturated;
  modport source (output valid, out_line, out_samp, saturated, input ready);
  modport sink   (input valid, out_line, out_samp, saturated, output ready);
endinterface

// ===== sv/radial_distortion_correct.sv =====
// Top level of the cubic radial lens distortion corrector.
// Depends on rdc_pkg, rdc_if, rdc_front, rdc_cell and rdc_back.
//
// Usage:
//   in_ch carries one word: operation (1 image->object, 0 object->image)
//   and a signed Q12.F line/sample pair. out_ch returns one word per input:
//   the converted pair, saturated to Q12.F, and a flag set when clamped.
//   Registers are written over cfg_we/cfg_index/cfg_wdata (0 camera mode,
//   1 axis line, 2 axis sample, 3 distortion constant) while idle.
// Timing:
//   A word passes 5 front stages, 32 root-search cells of 4 stages each
//   (three multiply stages and a compare) and 5 back stages including the
//   output register on its way from acceptance to out_ch.valid. One word per
//   cycle is taken while the output register is empty or being read.
// Reset:
//   rst_n clears all valid bits and loads mode 1, axis 512.0 and the
//   default constant; no clearing pass is needed.
// Stall:
//   When out_ch.ready is low with a word waiting, the whole pipeline holds
//   and in_ch.ready drops; nothing is lost or repeated.
module radial_distortion_correct #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rdc_in_if.sink                          in_ch,
  rdc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rdc_pkg::*;

  localparam int KW = PROD_W - 16 - 2 * COORD_FRAC_BITS;

  logic [MODE_W-1:0]  mode_r;
  logic [AXIS_W-1:0]  axis_line_r, axis_samp_r;
  logic [COEFF_W-1:0] coeff_r;
  logic               en;
  logic               vld_ch  [0:ROOT_CELLS];
  side_t              side_ch [0:ROOT_CELLS];
  logic [KW-1:0]      k_ch    [0:ROOT_CELLS];
  logic [M_W-1:0]     m_ch    [0:ROOT_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= RST_MODE;
      axis_line_r <= RST_AXIS;
      axis_samp_r <= RST_AXIS;
      coeff_r     <= RST_COEFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_MODE: mode_r      <= cfg_wdata[MODE_W-1:0];
        CFG_AXIS_LINE:   axis_line_r <= cfg_wdata[AXIS_W-1:0];
        CFG_AXIS_SAMP:   axis_samp_r <= cfg_wdata[AXIS_W-1:0];
        CFG_COEFF:       coeff_r     <= cfg_wdata[COEFF_W-1:0];
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign m_ch[0]     = '0;

  rdc_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .KW(KW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (in_ch.valid),
    .op_i      (in_ch.operation),
    .line_i    (in_ch.in_line),
    .samp_i    (in_ch.in_samp),
    .mode      (mode_r),
    .axis_line (axis_line_r),
    .axis_samp (axis_samp_r),
    .coeff     (coeff_r),
    .vld_o     (vld_ch[0]),
    .side_o    (side_ch[0]),
    .k_o       (k_ch[0])
  );

  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_cell
    rdc_cell #(.KW(KW), .BIT(ROOT_CELLS - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld_ch[i]),
      .side_i (side_ch[i]),
      .k_i    (k_ch[i]),
      .m_i    (m_ch[i]),
      .vld_o  (vld_ch[i+1]),
      .side_o (side_ch[i+1]),
      .k_o    (k_ch[i+1]),
      .m_o    (m_ch[i+1])
    );
  end

  rdc_back #(.KW(KW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .vld_i     (vld_ch[ROOT_CELLS]),
    .side_i    (side_ch[ROOT_CELLS]),
    .k_i       (k_ch[ROOT_CELLS]),
    .m_i       (m_ch[ROOT_CELLS]),
    .mode      (mode_r),
    .axis_line (axis_line_r),
    .axis_samp (axis_samp_r),
    .out_vld   (out_ch.valid),
    .out_line  (out_ch.out_line),
    .out_samp  (out_ch.out_samp),
    .out_sat   (out_ch.saturated)
  );
endmodule

// ===== sv/rdc_front.sv =====
// Front pipeline: centring, squared radius and the A*r^2 term k.
// Depends on rdc_pkg.
module rdc_front #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int KW = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic                          op_i,
  input  rdc_pkg::coord_t               line_i,
  input  rdc_pkg::coord_t               samp_i,
  input  logic [rdc_pkg::MODE_W-1:0]    mode,
  input  logic [rdc_pkg::AXIS_W-1:0]    axis_line,
  input  logic [rdc_pkg::AXIS_W-1:0]    axis_samp,
  input  logic [rdc_pkg::COEFF_W-1:0]   coeff,
  output logic                          vld_o,
  output rdc_pkg::side_t                side_o,
  output logic [KW-1:0]                 k_o
);
  import rdc_pkg::*;

  localparam int KSH = 16 + 2 * COORD_FRAC_BITS;
  localparam int SQ_W = 2 * DELTA_W;

  logic [1:0]  shift;
  delta_t      dx, dy;
  side_t       s1_r, s2_r, s3_r, s4_r, s5_r;
  side_t       s4_fwd;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [SQ_W-1:0] sqx2_r, sqy2_r;
  logic [R2_W-1:0]  r2_3_r;
  logic [COEFF_W+R2_HALF-1:0] plo4_r, phi4_r;
  logic        z4_r;
  logic [PROD_W-1:0] prod;
  logic [KW-1:0] k5_r;

  always_comb begin
    unique case (mode)
      MODE_SUM2: shift = 2'd1;
      MODE_SUM4: shift = 2'd2;
      MODE_NARROW, MODE_FULL: shift = 2'd0;
    endcase
  end

  assign dx = (delta_t'(samp_i) <<< shift) - delta_t'({5'd0, axis_samp});
  assign dy = (delta_t'(line_i) <<< shift) - delta_t'({5'd0, axis_line});

  assign prod = PROD_W'(plo4_r) + (PROD_W'(phi4_r) << R2_HALF);

  always_comb begin
    s4_fwd      = s4_r;
    // zero radius on the inverse path passes the word through
    s4_fwd.pass = s4_r.pass | (s4_r.op & z4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.op   <= op_i;
      s1_r.pass <= (mode == MODE_NARROW);
      s1_r.line <= line_i;
      s1_r.samp <= samp_i;
      s1_r.dx   <= dx;
      s1_r.dy   <= dy;
      s2_r      <= s1_r;
      sqx2_r    <= s1_r.dx * s1_r.dx;
      sqy2_r    <= s1_r.dy * s1_r.dy;
      s3_r      <= s2_r;
      r2_3_r    <= R2_W'(sqx2_r) + R2_W'(sqy2_r);
      s4_r      <= s3_r;
      z4_r      <= (r2_3_r == '0);
      plo4_r    <= (COEFF_W+R2_HALF)'(coeff) * (COEFF_W+R2_HALF)'(r2_3_r[R2_HALF-1:0]);
      phi4_r    <= (COEFF_W+R2_HALF)'(coeff) * (COEFF_W+R2_HALF)'(r2_3_r[R2_W-1:R2_HALF]);
      s5_r      <= s4_fwd;
      k5_r      <= prod[PROD_W-1:KSH];
    end
  end

  assign vld_o  = v5_r;
  assign side_o = s5_r;
  assign k_o    = k5_r;
endmodule

// ===== sv/rdc_cell.sv =====
// One bit of the inverse-scale search: keeps bit BIT of M when
// M + k*M^3 stays within one. Four register stages. Depends on rdc_pkg.
module rdc_cell #(
  parameter int KW  = 38,
  parameter int BIT = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  rdc_pkg::side_t         side_i,
  input  logic [KW-1:0]          k_i,
  input  logic [rdc_pkg::M_W-1:0] m_i,
  output logic                   vld_o,
  output rdc_pkg::side_t         side_o,
  output logic [KW-1:0]          k_o,
  output logic [rdc_pkg::M_W-1:0] m_o
);
  import rdc_pkg::*;

  localparam int KLO   = (KW + 1) / 2;
  localparam int KHI   = KW - KLO;
  localparam int P_W   = KW + M_W;
  localparam int CMP_W = (KW > M_W + 1) ? KW : M_W + 1;

  logic [M_W-1:0]   cand;
  logic             va_r, vb_r, vc_r, vd_r;
  side_t            sa_r, sb_r, sc_r, sd_r;
  logic [KW-1:0]    ka_r, kb_r, kc_r, kd_r;
  logic [M_W-1:0]   ma_r, mb_r, mc_r, md_r;
  logic [M_W-1:0]   ca_r, cb_r, cc_r;
  logic [2*M_W-1:0] sq_r, qc_r;
  logic [KLO+M_W-1:0] pl_r;
  logic [KHI+M_W-1:0] ph_r;
  logic [P_W-1:0]   psum;
  logic [M_W:0]     lim;
  logic             take;

  assign cand = m_i | (M_W'(1) << BIT);
  assign psum = P_W'(pl_r) + (P_W'(ph_r) << KLO);
  assign lim  = {1'b1, M_W'(0)} - {1'b0, cc_r};
  assign take = CMP_W'(psum[P_W-1:M_W]) <= CMP_W'(lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0; vd_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= side_i; sb_r <= sa_r; sc_r <= sb_r; sd_r <= sc_r;
      ka_r <= k_i;    kb_r <= ka_r; kc_r <= kb_r; kd_r <= kc_r;
      ma_r <= m_i;    mb_r <= ma_r; mc_r <= mb_r;
      ca_r <= cand;   cb_r <= ca_r; cc_r <= cb_r;
      sq_r <= {M_W'(0), cand} * {M_W'(0), cand};
      qc_r <= {M_W'(0), sq_r[2*M_W-1:M_W]} * {M_W'(0), ca_r};
      pl_r <= (KLO+M_W)'(kb_r[KLO-1:0]) * (KLO+M_W)'(qc_r[2*M_W-1:M_W]);
      ph_r <= (KHI+M_W)'(kb_r[KW-1:KLO]) * (KHI+M_W)'(qc_r[2*M_W-1:M_W]);
      md_r <= take ? cc_r : mc_r;
    end
  end

  assign vld_o  = vd_r;
  assign side_o = sd_r;
  assign k_o    = kd_r;
  assign m_o    = md_r;
endmodule

// ===== sv/rdc_back.sv =====
// Back pipeline: scales the offsets, restores the axis, undoes summation,
// clamps and holds the output register. Depends on rdc_pkg.
module rdc_back #(
  parameter int KW = 38
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  rdc_pkg::side_t              side_i,
  input  logic [KW-1:0]               k_i,
  input  logic [rdc_pkg::M_W-1:0]     m_i,
  input  logic [rdc_pkg::MODE_W-1:0]  mode,
  input  logic [rdc_pkg::AXIS_W-1:0]  axis_line,
  input  logic [rdc_pkg::AXIS_W-1:0]  axis_samp,
  output logic                        out_vld,
  output rdc_pkg::coord_t             out_line,
  output rdc_pkg::coord_t             out_samp,
  output logic                        out_sat
);
  import rdc_pkg::*;

  localparam int HP_W = MAG_W + S_HALF;
  localparam int FP_W = MAG_W + S_W;
  localparam int R_W  = FP_W - M_W;

  logic            v1_r, v2_r, v3_r, v4_r, ov_r;
  side_t           s1_r, s2_r, s3_r, s4_r;
  logic [S_W-1:0]  sc1_r;
  logic [MAG_W-1:0] my1_r, mx1_r;
  logic [HP_W-1:0] yl2_r, yh2_r, xl2_r, xh2_r;
  logic [R_W-1:0]  ry3_r, rx3_r;
  logic [FP_W-1:0] fy, fx;
  logic signed [V_W-1:0] vy4_r, vx4_r, ty, tx, qy, qx;
  logic [1:0]      shift;
  logic [V_W-1:0]  rnd;
  coord_t          cy, cx, ol_r, os_r;
  logic            saty, satx, osat_r;

  function automatic logic [MAG_W-1:0] mag(input delta_t d);
    delta_t a;
    a = d[DELTA_W-1] ? -d : d;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic signed [V_W-1:0] place(input logic neg,
      input logic [R_W-1:0] r, input logic [AXIS_W-1:0] ax);
    logic signed [V_W-1:0] off;
    off = $signed(V_W'(r));
    if (neg) off = -off;
    return off + $signed(V_W'(ax));
  endfunction

  always_comb begin
    unique case (mode)
      MODE_SUM2: begin shift = 2'd1; rnd = V_W'(1); end
      MODE_SUM4: begin shift = 2'd2; rnd = V_W'(2); end
      MODE_NARROW, MODE_FULL: begin shift = 2'd0; rnd = '0; end
    endcase
  end

  // rounding constant 2^31 before dropping the Q.32 fraction
  assign fy = FP_W'(yl2_r) + (FP_W'(yh2_r) << S_HALF) + (FP_W'(1) << (M_W - 1));
  assign fx = FP_W'(xl2_r) + (FP_W'(xh2_r) << S_HALF) + (FP_W'(1) << (M_W - 1));

  assign ty = vy4_r + $signed(rnd);
  assign tx = vx4_r + $signed(rnd);
  assign qy = ty >>> shift;
  assign qx = tx >>> shift;

  always_comb begin
    saty = 1'b0;
    satx = 1'b0;
    cy = qy[COORD_W-1:0];
    cx = qx[COORD_W-1:0];
    if (qy > V_W'(COORD_MAX)) begin cy = COORD_MAX; saty = 1'b1; end
    else if (qy < V_W'(COORD_MIN)) begin cy = COORD_MIN; saty = 1'b1; end
    if (qx > V_W'(COORD_MAX)) begin cx = COORD_MAX; satx = 1'b1; end
    else if (qx < V_W'(COORD_MIN)) begin cx = COORD_MIN; satx = 1'b1; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= side_i;
      sc1_r <= side_i.op ? S_W'(m_i) : (S_W'(1) << M_W) + S_W'(k_i);
      my1_r <= mag(side_i.dy);
      mx1_r <= mag(side_i.dx);
      s2_r  <= s1_r;
      yl2_r <= HP_W'(my1_r) * HP_W'(sc1_r[S_HALF-1:0]);
      yh2_r <= HP_W'(my1_r) * HP_W'(sc1_r[S_W-1:S_HALF]);
      xl2_r <= HP_W'(mx1_r) * HP_W'(sc1_r[S_HALF-1:0]);
      xh2_r <= HP_W'(mx1_r) * HP_W'(sc1_r[S_W-1:S_HALF]);
      s3_r  <= s2_r;
      ry3_r <= fy[FP_W-1:M_W];
      rx3_r <= fx[FP_W-1:M_W];
      s4_r  <= s3_r;
      vy4_r <= place(s3_r.dy[DELTA_W-1], ry3_r, axis_line);
      vx4_r <= place(s3_r.dx[DELTA_W-1], rx3_r, axis_samp);
      if (s4_r.pass) begin
        ol_r   <= s4_r.line;
        os_r   <= s4_r.samp;
        osat_r <= 1'b0;
      end else begin
        ol_r   <= cy;
        os_r   <= cx;
        osat_r <= saty | satx;
      end
    end
  end

  assign out_vld  = ov_r;
  assign out_line = ol_r;
  assign out_samp = os_r;
  assign out_sat  = osat_r;
endmodule
